FILE: src/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Types and constants shared by the oriented rectangle overlap test blocks.
// ----------------------------------------------------------------------------
package obb_pkg;

    // registered steps inside one axis cell, and the whole chain plus output
    localparam int CELL_STAGES = 5;
    localparam int NUM_AXES    = 4;
    localparam int PIPE_DEPTH  = NUM_AXES * CELL_STAGES + 1;

    // axis order along the chain
    localparam int AXIS_A_U = 0;
    localparam int AXIS_A_V = 1;
    localparam int AXIS_B_U = 2;
    localparam int AXIS_B_V = 3;

    // squared axis length at or below this (Q2.28) means the axis is skipped
    localparam logic signed [34:0] NEAR_ZERO_SQ = 35'sd2;

    typedef struct packed {
        logic signed [23:0] a_center_x;
        logic signed [23:0] a_center_y;
        logic signed [15:0] a_axis_x;
        logic signed [15:0] a_axis_y;
        logic        [22:0] a_half_u;
        logic        [22:0] a_half_v;
        logic signed [23:0] b_center_x;
        logic signed [23:0] b_center_y;
        logic signed [15:0] b_axis_x;
        logic signed [15:0] b_axis_y;
        logic        [22:0] b_half_u;
        logic        [22:0] b_half_v;
    } obb_in_t;

    typedef struct packed {
        logic               collides;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
    } obb_out_t;

    // running result handed from cell to cell
    typedef struct packed {
        logic               alive;   // no separating axis found so far
        logic               have;    // at least one axis tested
        logic signed [57:0] best;    // smallest overlap, Q.36
        logic signed [15:0] nx;
        logic signed [15:0] ny;
    } obb_acc_t;

    typedef struct packed {
        obb_in_t  item;
        obb_acc_t acc;
    } obb_bus_t;

    typedef struct packed {
        logic signed [16:0] lx;
        logic signed [16:0] ly;
    } obb_axis_t;

    // candidate axis of the given index; the second axis is (-u.y, u.x)
    function automatic obb_axis_t obb_axis(input obb_in_t it, input int idx);
        obb_axis_t ax;
        case (idx)
            AXIS_A_U: begin
                ax.lx = 17'(it.a_axis_x);
                ax.ly = 17'(it.a_axis_y);
            end
            AXIS_A_V: begin
                ax.lx = -17'(it.a_axis_y);
                ax.ly = 17'(it.a_axis_x);
            end
            AXIS_B_U: begin
                ax.lx = 17'(it.b_axis_x);
                ax.ly = 17'(it.b_axis_y);
            end
            default: begin
                ax.lx = -17'(it.b_axis_y);
                ax.ly = 17'(it.b_axis_x);
            end
        endcase
        return ax;
    endfunction

endpackage

FILE: src/obb_cell.sv
// ----------------------------------------------------------------------------
// obb_cell
// One axis of the separating axis test: projects both rectangles and the
// center offset on its axis and folds the overlap into the running result.
// ----------------------------------------------------------------------------
module obb_cell
    import obb_pkg::*;
#(
    parameter int AXIS = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  obb_bus_t in_bus,
    output logic     out_valid,
    input  logic     out_ready,
    output obb_bus_t out_bus
);

    typedef struct packed {
        obb_bus_t           bus;
        logic signed [32:0] pa_uu;   // a.x * lx
        logic signed [32:0] pa_vv;   // a.y * ly
        logic signed [32:0] pa_uv;   // a.y * lx
        logic signed [32:0] pa_vu;   // a.x * ly
        logic signed [32:0] pb_uu;
        logic signed [32:0] pb_vv;
        logic signed [32:0] pb_uv;
        logic signed [32:0] pb_vu;
        logic signed [41:0] pd_x;
        logic signed [41:0] pd_y;
        logic signed [33:0] sq_x;
        logic signed [33:0] sq_y;
    } st1_t;

    typedef struct packed {
        obb_bus_t    bus;
        logic [31:0] m_au;
        logic [31:0] m_av;
        logic [31:0] m_bu;
        logic [31:0] m_bv;
        logic [40:0] m_d;
        logic        neg;
        logic        skip;
    } st2_t;

    typedef struct packed {
        obb_bus_t    bus;
        logic [54:0] r_au;
        logic [54:0] r_av;
        logic [54:0] r_bu;
        logic [54:0] r_bv;
        logic [40:0] m_d;
        logic        neg;
        logic        skip;
    } st3_t;

    typedef struct packed {
        obb_bus_t           bus;
        logic signed [57:0] ov;
        logic               neg;
        logic               skip;
    } st4_t;

    st1_t     s1_reg, s1_next;
    st2_t     s2_reg, s2_next;
    st3_t     s3_reg, s3_next;
    st4_t     s4_reg, s4_next;
    obb_bus_t out_reg, out_next;
    logic [CELL_STAGES-1:0] v_reg;
    logic [CELL_STAGES-1:0] rdy;

    // a stage takes new data when empty or when its contents move on
    always_comb begin
        rdy[CELL_STAGES-1] = !v_reg[CELL_STAGES-1] || out_ready;
        for (int k = CELL_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[CELL_STAGES-1];
    assign out_bus   = out_reg;

    // products of the axis with both frames and the center offset
    always_comb begin
        obb_axis_t          l;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        l  = obb_axis(in_bus.item, AXIS);
        dx = 25'(in_bus.item.b_center_x) - 25'(in_bus.item.a_center_x);
        dy = 25'(in_bus.item.b_center_y) - 25'(in_bus.item.a_center_y);
        s1_next.bus   = in_bus;
        s1_next.pa_uu = 33'(in_bus.item.a_axis_x) * 33'(l.lx);
        s1_next.pa_vv = 33'(in_bus.item.a_axis_y) * 33'(l.ly);
        s1_next.pa_uv = 33'(in_bus.item.a_axis_y) * 33'(l.lx);
        s1_next.pa_vu = 33'(in_bus.item.a_axis_x) * 33'(l.ly);
        s1_next.pb_uu = 33'(in_bus.item.b_axis_x) * 33'(l.lx);
        s1_next.pb_vv = 33'(in_bus.item.b_axis_y) * 33'(l.ly);
        s1_next.pb_uv = 33'(in_bus.item.b_axis_y) * 33'(l.lx);
        s1_next.pb_vu = 33'(in_bus.item.b_axis_x) * 33'(l.ly);
        s1_next.pd_x  = 42'(dx) * 42'(l.lx);
        s1_next.pd_y  = 42'(dy) * 42'(l.ly);
        s1_next.sq_x  = 34'(l.lx) * 34'(l.lx);
        s1_next.sq_y  = 34'(l.ly) * 34'(l.ly);
    end

    // dot products and their magnitudes
    always_comb begin
        logic signed [33:0] du_a;
        logic signed [33:0] dv_a;
        logic signed [33:0] du_b;
        logic signed [33:0] dv_b;
        logic signed [42:0] dl;
        logic signed [34:0] len2;
        logic signed [33:0] abs_au;
        logic signed [33:0] abs_av;
        logic signed [33:0] abs_bu;
        logic signed [33:0] abs_bv;
        logic signed [42:0] abs_d;
        du_a = 34'(s1_reg.pa_uu) + 34'(s1_reg.pa_vv);
        dv_a = 34'(s1_reg.pa_vu) - 34'(s1_reg.pa_uv);
        du_b = 34'(s1_reg.pb_uu) + 34'(s1_reg.pb_vv);
        dv_b = 34'(s1_reg.pb_vu) - 34'(s1_reg.pb_uv);
        dl   = 43'(s1_reg.pd_x) + 43'(s1_reg.pd_y);
        len2 = 35'(s1_reg.sq_x) + 35'(s1_reg.sq_y);
        abs_au = du_a[33] ? -du_a : du_a;
        abs_av = dv_a[33] ? -dv_a : dv_a;
        abs_bu = du_b[33] ? -du_b : du_b;
        abs_bv = dv_b[33] ? -dv_b : dv_b;
        abs_d  = dl[42] ? -dl : dl;
        s2_next.bus  = s1_reg.bus;
        s2_next.m_au = abs_au[31:0];
        s2_next.m_av = abs_av[31:0];
        s2_next.m_bu = abs_bu[31:0];
        s2_next.m_bv = abs_bv[31:0];
        s2_next.m_d  = abs_d[40:0];
        s2_next.neg  = dl[42];
        s2_next.skip = (len2 <= NEAR_ZERO_SQ);
    end

    // projected radii, Q.36
    always_comb begin
        s3_next.bus  = s2_reg.bus;
        s3_next.r_au = 55'(s2_reg.bus.item.a_half_u) * 55'(s2_reg.m_au);
        s3_next.r_av = 55'(s2_reg.bus.item.a_half_v) * 55'(s2_reg.m_av);
        s3_next.r_bu = 55'(s2_reg.bus.item.b_half_u) * 55'(s2_reg.m_bu);
        s3_next.r_bv = 55'(s2_reg.bus.item.b_half_v) * 55'(s2_reg.m_bv);
        s3_next.m_d  = s2_reg.m_d;
        s3_next.neg  = s2_reg.neg;
        s3_next.skip = s2_reg.skip;
    end

    // overlap on this axis
    always_comb begin
        logic [56:0] rsum;
        logic [54:0] tmag;
        rsum = (57'(s3_reg.r_au) + 57'(s3_reg.r_av))
             + (57'(s3_reg.r_bu) + 57'(s3_reg.r_bv));
        tmag = {s3_reg.m_d, 14'd0};
        s4_next.bus  = s3_reg.bus;
        s4_next.ov   = $signed(58'(rsum) - 58'(tmag));
        s4_next.neg  = s3_reg.neg;
        s4_next.skip = s3_reg.skip;
    end

    // fold into the running result; the first axis keeps ties
    always_comb begin
        obb_axis_t l;
        logic      sep;
        l        = obb_axis(s4_reg.bus.item, AXIS);
        sep      = s4_reg.ov[57] || (s4_reg.ov == '0);
        out_next = s4_reg.bus;
        if (s4_reg.bus.acc.alive && !s4_reg.skip) begin
            if (sep) begin
                out_next.acc.alive = 1'b0;
            end else if (!s4_reg.bus.acc.have || (s4_reg.ov < s4_reg.bus.acc.best)) begin
                out_next.acc.have = 1'b1;
                out_next.acc.best = s4_reg.ov;
                out_next.acc.nx   = s4_reg.neg ? -l.lx[15:0] : l.lx[15:0];
                out_next.acc.ny   = s4_reg.neg ? -l.ly[15:0] : l.ly[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < CELL_STAGES; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s1_reg <= s1_next;
        end
        if (rdy[1]) begin
            s2_reg <= s2_next;
        end
        if (rdy[2]) begin
            s3_reg <= s3_next;
        end
        if (rdy[3]) begin
            s4_reg <= s4_next;
        end
        if (rdy[4]) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: src/obb_pair_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// obb_pair_overlap_test_unit
// Separating axis test for two oriented rectangles, one axis per cell.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | obb_in_t  (two rectangles)
//  m_      | out       | m_valid / m_ready | obb_out_t (collides, normal)
//
//  One pair per cycle sustained while m_ready is high. Each result passes
//  through the chain of four axis cells, five registered steps
//  each (products, dot sums, radius products, overlap, fold), plus the output
//  register. Synchronous active-low reset empties the pipeline. A stall on m_
//  backs up one stage at a time, so empty stages keep accepting.
// ----------------------------------------------------------------------------
module obb_pair_overlap_test_unit
    import obb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  obb_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output obb_out_t m_data
);

    logic     c_valid [NUM_AXES+1];
    logic     c_ready [NUM_AXES+1];
    obb_bus_t c_bus   [NUM_AXES+1];

    logic     m_valid_reg, m_valid_next;
    obb_out_t m_data_reg, m_data_next;
    logic     out_rdy;

    assign c_valid[0]          = s_valid;
    assign s_ready             = c_ready[0];
    assign c_bus[0].item       = s_data;
    assign c_bus[0].acc.alive  = 1'b1;
    assign c_bus[0].acc.have   = 1'b0;
    assign c_bus[0].acc.best   = '0;
    assign c_bus[0].acc.nx     = '0;
    assign c_bus[0].acc.ny     = '0;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_cell
        obb_cell #(
            .AXIS(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (c_valid[i]),
            .in_ready (c_ready[i]),
            .in_bus   (c_bus[i]),
            .out_valid(c_valid[i+1]),
            .out_ready(c_ready[i+1]),
            .out_bus  (c_bus[i+1])
        );
    end

    assign out_rdy              = !m_valid_reg || m_ready;
    assign c_ready[NUM_AXES]    = out_rdy;

    always_comb begin
        logic hit;
        hit          = c_bus[NUM_AXES].acc.alive && c_bus[NUM_AXES].acc.have;
        m_valid_next = m_valid_reg;
        if (out_rdy) begin
            m_valid_next = c_valid[NUM_AXES];
        end
        m_data_next.collides = hit;
        m_data_next.normal_x = hit ? c_bus[NUM_AXES].acc.nx : 16'sd0;
        m_data_next.normal_y = hit ? c_bus[NUM_AXES].acc.ny : 16'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/obb_checker.sv
// ----------------------------------------------------------------------------
// obb_checker
// Port-level checks on the rectangle overlap unit, bound to the top level.
// ----------------------------------------------------------------------------
module obb_checker
    import obb_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input obb_out_t m_data
);

    localparam int CW = $clog2(PIPE_DEPTH + 2);

    logic [CW-1:0] count_reg, count_next;
    logic          s_fire;
    logic          m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // transactions in flight
    always_comb begin
        count_next = count_reg;
        if (s_fire && !m_fire) begin
            count_next = count_reg + CW'(1);
        end else if (m_fire && !s_fire) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.collides |-> m_data.normal_x == 16'sd0
                                     && m_data.normal_y == 16'sd0)
        else $error("normal not zero without collision");

    a_hit_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.collides |-> m_data.normal_x != 16'sd0
                                    || m_data.normal_y != 16'sd0)
        else $error("collision reported with zero normal");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> count_reg != '0)
        else $error("result without a pending transaction");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

endmodule

bind obb_pair_overlap_test_unit obb_checker u_obb_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for obb_pair_overlap_test_unit: drives rectangle pairs through the
// s_ channel and checks every collision/normal result on m_ against an
// in-bench separating axis predictor, under varying source and sink idling.
// ----------------------------------------------------------------------------
module tb_top;
    import obb_pkg::*;

    localparam int ONE            = 16384;   // 1.0 in Q1.14
    localparam int UNIT_LEN       = 256;     // 1.0 in Q15.8
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 383;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } dir_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    obb_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    obb_out_t m_data;

    obb_in_t  pending_pairs[$];
    obb_out_t expected_contacts[$];
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       mismatch_count = 0;
    int       quiet_cycles   = 0;

    obb_pair_overlap_test_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // projected half width of one rectangle onto axis (lx, ly), Q.36
    function automatic longint axis_reach(input longint hu, input longint hv,
                                          input longint ux, input longint uy,
                                          input longint lx, input longint ly);
        longint along_u, along_v;
        along_u = ux * lx + uy * ly;
        along_v = -uy * lx + ux * ly;
        return hu * abs64(along_u) + hv * abs64(along_v);
    endfunction

    function automatic obb_out_t predict_contact(input obb_in_t p);
        longint   ax, ay, bx, by, ahu, ahv, bhu, bhv, dx, dy;
        longint   lx[4], ly[4];
        longint   proj, gap, best, nx, ny;
        bit       have, separated;
        obb_out_t r;
        ax  = longint'(p.a_axis_x);
        ay  = longint'(p.a_axis_y);
        bx  = longint'(p.b_axis_x);
        by  = longint'(p.b_axis_y);
        ahu = longint'(p.a_half_u);
        ahv = longint'(p.a_half_v);
        bhu = longint'(p.b_half_u);
        bhv = longint'(p.b_half_v);
        dx  = longint'(p.b_center_x) - longint'(p.a_center_x);
        dy  = longint'(p.b_center_y) - longint'(p.a_center_y);
        lx[AXIS_A_U] = ax;  ly[AXIS_A_U] = ay;
        lx[AXIS_A_V] = -ay; ly[AXIS_A_V] = ax;
        lx[AXIS_B_U] = bx;  ly[AXIS_B_U] = by;
        lx[AXIS_B_V] = -by; ly[AXIS_B_V] = bx;
        have      = 1'b0;
        separated = 1'b0;
        best      = 0;
        nx        = 0;
        ny        = 0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (lx[i] * lx[i] + ly[i] * ly[i] <= longint'(NEAR_ZERO_SQ))
                continue;
            proj = (dx * lx[i] + dy * ly[i]) * 16384;
            gap  = axis_reach(ahu, ahv, ax, ay, lx[i], ly[i])
                 + axis_reach(bhu, bhv, bx, by, lx[i], ly[i]) - abs64(proj);
            if (gap <= 0) begin
                separated = 1'b1;
                break;
            end
            if (!have || gap < best) begin
                have = 1'b1;
                best = gap;
                nx   = (proj < 0) ? -lx[i] : lx[i];
                ny   = (proj < 0) ? -ly[i] : ly[i];
            end
        end
        r = '0;
        if (have && !separated) begin
            r.collides = 1'b1;
            r.normal_x = nx[15:0];
            r.normal_y = ny[15:0];
        end
        return r;
    endfunction

    function automatic obb_in_t rect_pair(input int acx, input int acy, input int aux,
                                          input int auy, input int ahu, input int ahv,
                                          input int bcx, input int bcy, input int bux,
                                          input int buy, input int bhu, input int bhv);
        obb_in_t p;
        p.a_center_x = 24'(acx);
        p.a_center_y = 24'(acy);
        p.a_axis_x   = 16'(aux);
        p.a_axis_y   = 16'(auy);
        p.a_half_u   = 23'(ahu);
        p.a_half_v   = 23'(ahv);
        p.b_center_x = 24'(bcx);
        p.b_center_y = 24'(bcy);
        p.b_axis_x   = 16'(bux);
        p.b_axis_y   = 16'(buy);
        p.b_half_u   = 23'(bhu);
        p.b_half_v   = 23'(bhv);
        return p;
    endfunction

    // unit direction at a random angle, or a cardinal one when asked
    function automatic dir_t random_dir(input bit cardinal);
        dir_t d;
        real  ang, c, s;
        if (cardinal) begin
            case ($urandom_range(3))
                0: begin d.x = 16'(ONE);  d.y = '0; end
                1: begin d.x = 16'(-ONE); d.y = '0; end
                2: begin d.x = '0; d.y = 16'(ONE);  end
                default: begin d.x = '0; d.y = 16'(-ONE); end
            endcase
        end else begin
            ang = $urandom_range(0, 71999) * 3.14159265358979 / 36000.0;
            c   = $cos(ang) * 16384.0;
            s   = $sin(ang) * 16384.0;
            d.x = 16'($rtoi(c >= 0.0 ? c + 0.5 : c - 0.5));
            d.y = 16'($rtoi(s >= 0.0 ? s + 0.5 : s - 0.5));
        end
        return d;
    endfunction

    function automatic obb_in_t random_pair();
        obb_in_t p;
        dir_t    da, db;
        int      kind, scale, span;
        bit      cardinal;
        kind = $urandom_range(99);
        if (kind < 20) begin
            // noise: any field value, axes mostly in range
            p.a_center_x = 24'($urandom);
            p.a_center_y = 24'($urandom);
            p.b_center_x = 24'($urandom);
            p.b_center_y = 24'($urandom);
            p.a_half_u   = 23'($urandom);
            p.a_half_v   = 23'($urandom);
            p.b_half_u   = 23'($urandom);
            p.b_half_v   = 23'($urandom);
            if ($urandom_range(3) == 0) begin
                p.a_axis_x = 16'($urandom);
                p.a_axis_y = 16'($urandom);
                p.b_axis_x = 16'($urandom);
                p.b_axis_y = 16'($urandom);
            end else begin
                p.a_axis_x = 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
                p.a_axis_y = 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
                p.b_axis_x = 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
                p.b_axis_y = 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
            end
        end else begin
            // nearby rectangles of similar size so both outcomes are common
            cardinal     = (kind < 35);
            da           = random_dir(cardinal);
            db           = random_dir(cardinal);
            scale        = $urandom_range(2, 22);
            span         = 1 << (scale + 1);
            p.a_half_u   = 23'($urandom_range(0, 1 << scale));
            p.a_half_v   = 23'($urandom_range(0, 1 << scale));
            p.b_half_u   = 23'($urandom_range(0, 1 << scale));
            p.b_half_v   = 23'($urandom_range(0, 1 << scale));
            p.a_center_x = 24'($urandom);
            p.a_center_y = 24'($urandom);
            p.b_center_x = p.a_center_x + 24'(int'($urandom_range(0, 2 * span)) - span);
            p.b_center_y = p.a_center_y + 24'(int'($urandom_range(0, 2 * span)) - span);
            p.a_axis_x   = da.x;
            p.a_axis_y   = da.y;
            p.b_axis_x   = db.x;
            p.b_axis_y   = db.y;
        end
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || s_valid || expected_contacts.size() != 0)
            @(negedge aclk);
    endtask

    // source side: one transaction at a time from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_contacts.push_back(predict_contact(s_data));
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_pairs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        obb_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_contacts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: collides=%0b normal=(%0d,%0d)",
                             m_data.collides, m_data.normal_x, m_data.normal_y);
            end else begin
                want = expected_contacts.pop_front();
                if (m_data.collides !== want.collides || m_data.normal_x !== want.normal_x ||
                    m_data.normal_y !== want.normal_y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected collides=%0b normal=(%0d,%0d),",
                                  " got %0b (%0d,%0d)"},
                                 want.collides, want.normal_x, want.normal_y,
                                 m_data.collides, m_data.normal_x, m_data.normal_y);
                end
            end
        end
    end

    // ends the run if no transaction moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** obb_pair_overlap_test_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int send_plan[4];
        int stall_plan[4];
        send_plan  = '{0, 60, 0, 28};
        stall_plan = '{0, 0, 60, 28};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero everything: no axis is tested
        pending_pairs.push_back(rect_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // identical squares: all overlaps tie, first axis wins
        pending_pairs.push_back(rect_pair(0, 0, ONE, 0, UNIT_LEN, UNIT_LEN,
                                          0, 0, ONE, 0, UNIT_LEN, UNIT_LEN));
        pending_pairs.push_back(rect_pair(0, 0, ONE, 0, UNIT_LEN, UNIT_LEN,
                                          300, 0, ONE, 0, UNIT_LEN, UNIT_LEN));
        // B on the negative side: normal flips
        pending_pairs.push_back(rect_pair(0, 0, ONE, 0, UNIT_LEN, UNIT_LEN,
                                          -300, 40, ONE, 0, UNIT_LEN, UNIT_LEN));
        // exactly touching counts as separated
        pending_pairs.push_back(rect_pair(0, 0, ONE, 0, UNIT_LEN, UNIT_LEN,
                                          512, 0, ONE, 0, UNIT_LEN, UNIT_LEN));
        pending_pairs.push_back(rect_pair(0, 0, ONE, 0, UNIT_LEN, UNIT_LEN,
                                          0, -2000, ONE, 0, UNIT_LEN, UNIT_LEN));
        // A axes skipped, only B tested
        pending_pairs.push_back(rect_pair(0, 0, 0, 0, UNIT_LEN, UNIT_LEN,
                                          100, 100, ONE, 0, UNIT_LEN, UNIT_LEN));
        // B axes skipped, only A tested
        pending_pairs.push_back(rect_pair(0, 0, 0, ONE, UNIT_LEN, UNIT_LEN,
                                          0, 100, 0, 0, UNIT_LEN, UNIT_LEN));
        // squared length at the skip threshold for A and below it for B
        pending_pairs.push_back(rect_pair(0, 0, 1, 1, UNIT_LEN, UNIT_LEN,
                                          10, 10, -1, 0, UNIT_LEN, UNIT_LEN));
        // tiny non-unit axis just above the threshold
        pending_pairs.push_back(rect_pair(0, 0, 2, 0, UNIT_LEN, UNIT_LEN,
                                          10, 0, 0, 0, UNIT_LEN, UNIT_LEN));
        // most negative component: negated normal wraps within 16 bits
        pending_pairs.push_back(rect_pair(0, 0, -32768, 0, UNIT_LEN, UNIT_LEN,
                                          -100, 50, ONE, 0, UNIT_LEN, UNIT_LEN));
        pending_pairs.push_back(rect_pair(0, 0, 0, -32768, UNIT_LEN, UNIT_LEN,
                                          100, -30, 0, ONE, UNIT_LEN, UNIT_LEN));
        pending_pairs.push_back(rect_pair(0, 0, 32767, -1, UNIT_LEN, UNIT_LEN,
                                          1, 1, -32768, -32768, UNIT_LEN, UNIT_LEN));
        // field extremes
        pending_pairs.push_back(rect_pair(-8388608, -8388608, -ONE, 0, 8388607, 8388607,
                                          8388607, 8388607, 0, -ONE, 8388607, 8388607));
        pending_pairs.push_back(rect_pair(8388607, -8388608, ONE, ONE, 8388607, 0,
                                          -8388608, 8388607, -ONE, ONE, 0, 8388607));
        pending_pairs.push_back(rect_pair(-8388608, 8388607, ONE, 0, 8388607, 8388607,
                                          -8388608, 8388607, -ONE, 0, 8388607, 8388607));
        // rotated rectangles, overlapping and apart
        pending_pairs.push_back(rect_pair(0, 0, 11585, 11585, 4 * UNIT_LEN, UNIT_LEN,
                                          600, 600, ONE, 0, UNIT_LEN, 2 * UNIT_LEN));
        pending_pairs.push_back(rect_pair(0, 0, ONE, 0, UNIT_LEN, UNIT_LEN,
                                          700, 0, 11585, 11585, UNIT_LEN, UNIT_LEN));
        // degenerate rectangles at the same point
        pending_pairs.push_back(rect_pair(5, 5, ONE, 0, 0, 0, 5, 5, 0, ONE, 0, 0));

        // hold the source until the pipeline is empty
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_plan[ph];
            recv_stall_pct = stall_plan[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_pairs.push_back(random_pair());
            wait_drained();
        end

        repeat (PIPE_DEPTH + 8) @(posedge aclk);
        if (mismatch_count == 0 && expected_contacts.size() == 0) begin
            $display("** obb_pair_overlap_test_unit: PASSED **");
        end else begin
            $display("** obb_pair_overlap_test_unit: FAILED **");
        end
        $finish;
    end

endmodule
